// ===== hdl/jsac_pkg.sv =====
// Shared constants, register codes and types for the joystick axis auto-calibration unit.
package jsac_pkg;

  // Field widths fixed by the sample and result formats.
  localparam int unsigned AXIS_W = 8;
  localparam int unsigned TIME_W = 16;
  localparam int unsigned DEFL_W = 16;

  // Configuration port geometry: six 32-bit registers at word addresses.
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned IDX_W  = 3;

  // Register indexes, taken from paddr[4:2].
  localparam logic [IDX_W-1:0] REG_CALIBRATE_ON = 3'd0;
  localparam logic [IDX_W-1:0] REG_WAKE_BELOW   = 3'd1;
  localparam logic [IDX_W-1:0] REG_WAKE_ABOVE   = 3'd2;
  localparam logic [IDX_W-1:0] REG_REST_LOW     = 3'd3;
  localparam logic [IDX_W-1:0] REG_REST_HIGH    = 3'd4;
  localparam logic [IDX_W-1:0] REG_DWELL_LIMIT  = 3'd5;

  // Reset values of the configuration registers.
  localparam logic              RST_CALIBRATE_ON = 1'b1;
  localparam logic [AXIS_W-1:0] RST_WAKE_BELOW   = 8'd64;
  localparam logic [AXIS_W-1:0] RST_WAKE_ABOVE   = 8'd192;
  localparam logic [AXIS_W-1:0] RST_REST_LOW     = 8'd96;
  localparam logic [AXIS_W-1:0] RST_REST_HIGH    = 8'd160;
  localparam logic [TIME_W-1:0] RST_DWELL_LIMIT  = 16'd500;

  // Reset values of the calibration state.
  localparam logic [AXIS_W-1:0] RST_RANGE_LOW   = 8'd0;
  localparam logic [AXIS_W-1:0] RST_RANGE_HIGH  = 8'd255;
  localparam logic [AXIS_W-1:0] RST_CENTER_LOW  = 8'd120;
  localparam logic [AXIS_W-1:0] RST_CENTER_HIGH = 8'd134;

  // Fraction bits produced by the serial divider, and its step counter width.
  localparam int unsigned DIV_STEPS = 15;
  localparam int unsigned CNT_W     = 4;
  localparam logic [DEFL_W-1:0] MAX_MAG = 16'd32767;

  // Configuration register file contents.
  typedef struct packed {
    logic              calibrate_on;
    logic [AXIS_W-1:0] wake_below;
    logic [AXIS_W-1:0] wake_above;
    logic [AXIS_W-1:0] rest_window_low;
    logic [AXIS_W-1:0] rest_window_high;
    logic [TIME_W-1:0] dwell_limit_ms;
  } cfg_t;

  // Calibration state visible to the conversion path.
  typedef struct packed {
    logic              armed;
    logic [AXIS_W-1:0] range_low;
    logic [AXIS_W-1:0] range_high;
    logic [AXIS_W-1:0] center_low;
    logic [AXIS_W-1:0] center_high;
  } cal_t;

  // Divider launch request.
  typedef struct packed {
    logic              start;
    logic [AXIS_W-1:0] num;
    logic [AXIS_W-1:0] den;
  } div_req_t;

  // Divider result, with done as a single-cycle pulse.
  typedef struct packed {
    logic              done;
    logic [DEFL_W-1:0] mag;
  } div_res_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SETUP = 4'b0010,
    ST_DIV   = 4'b0100,
    ST_HOLD  = 4'b1000
  } state_t;

endpackage

// ===== hdl/jsac_if.sv =====
// Valid/ready channel interfaces for axis samples and normalised results.
interface jsac_in_if;
  logic                              valid;
  logic                              ready;
  logic [jsac_pkg::AXIS_W-1:0]       axis_value;
  logic [jsac_pkg::TIME_W-1:0]       elapsed_ms;

  modport source (output valid, output axis_value, output elapsed_ms, input ready);
  modport sink   (input valid, input axis_value, input elapsed_ms, output ready);
endinterface

interface jsac_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [jsac_pkg::DEFL_W-1:0] deflection;
  logic [jsac_pkg::AXIS_W-1:0]       out_range_low;
  logic [jsac_pkg::AXIS_W-1:0]       out_range_high;
  logic [jsac_pkg::AXIS_W-1:0]       out_center_low;
  logic [jsac_pkg::AXIS_W-1:0]       out_center_high;
  logic [jsac_pkg::AXIS_W-1:0]       out_center_mid;
  logic                              out_armed;

  modport source (output valid, output deflection, output out_range_low,
                  output out_range_high, output out_center_low, output out_center_high,
                  output out_center_mid, output out_armed, input ready);
  modport sink   (input valid, input deflection, input out_range_low,
                  input out_range_high, input out_center_low, input out_center_high,
                  input out_center_mid, input out_armed, output ready);
endinterface

// ===== hdl/joystick_axis_autocal_normalizer_unit.sv =====
// Top level of the single-axis joystick auto-calibration and normalisation unit.
//
//  Channel   Role    Handshake                 Carries
//  in_ch     sink    valid/ready               axis_value, elapsed_ms
//  out_ch    source  valid/ready               deflection, range, dead band, armed
//  APB       slave   psel/penable, pready=1    six configuration registers
//
// Each sample goes from transfer to result through these steps: launch of the divider on the
// updated calibration, the bit-serial divider, the sign, and the output register load; a
// sample in the dead band skips the divider. Calibration itself is updated at the transfer edge.
// Most of a sample's time goes to the divider's one-bit-per-cycle loop. A new sample is taken
// only once the previous one has reached the output register, so samples never overlap,
// and a result that the sink holds back stalls the input. Reset is synchronous.
module joystick_axis_autocal_normalizer_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  jsac_in_if.sink                      in_ch,
  jsac_out_if.source                   out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [jsac_pkg::ADDR_W-1:0]  paddr,
  input  logic [jsac_pkg::DATA_W-1:0]  pwdata,
  output logic [jsac_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);

  jsac_pkg::cfg_t     cfg_r;
  jsac_pkg::cal_t     cal;
  jsac_pkg::div_req_t div_req;
  jsac_pkg::div_res_t div_res;
  jsac_pkg::state_t   state_r, state_nxt;

  logic                        in_acc, out_free, cfg_wr;
  logic [jsac_pkg::IDX_W-1:0]  cfg_idx;
  logic [jsac_pkg::AXIS_W-1:0] sample_r, x_clamp;
  logic                        pos_side, neg_side;
  logic                        neg_r;
  logic [jsac_pkg::DEFL_W-1:0] defl_r;
  logic [jsac_pkg::AXIS_W:0]   mid_sum;

  logic                        out_valid_r;
  logic [jsac_pkg::DEFL_W-1:0] out_defl_r;
  logic [jsac_pkg::AXIS_W-1:0] out_rl_r, out_rh_r, out_cl_r, out_ch_r, out_mid_r;
  logic                        out_armed_r;

  // Configuration port: writes complete in the access phase, no wait states.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[jsac_pkg::ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{calibrate_on:     jsac_pkg::RST_CALIBRATE_ON,
                 wake_below:       jsac_pkg::RST_WAKE_BELOW,
                 wake_above:       jsac_pkg::RST_WAKE_ABOVE,
                 rest_window_low:  jsac_pkg::RST_REST_LOW,
                 rest_window_high: jsac_pkg::RST_REST_HIGH,
                 dwell_limit_ms:   jsac_pkg::RST_DWELL_LIMIT};
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        jsac_pkg::REG_CALIBRATE_ON: cfg_r.calibrate_on     <= pwdata[0];
        jsac_pkg::REG_WAKE_BELOW:   cfg_r.wake_below       <= pwdata[jsac_pkg::AXIS_W-1:0];
        jsac_pkg::REG_WAKE_ABOVE:   cfg_r.wake_above       <= pwdata[jsac_pkg::AXIS_W-1:0];
        jsac_pkg::REG_REST_LOW:     cfg_r.rest_window_low  <= pwdata[jsac_pkg::AXIS_W-1:0];
        jsac_pkg::REG_REST_HIGH:    cfg_r.rest_window_high <= pwdata[jsac_pkg::AXIS_W-1:0];
        jsac_pkg::REG_DWELL_LIMIT:  cfg_r.dwell_limit_ms   <= pwdata[jsac_pkg::TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (cfg_idx)
      jsac_pkg::REG_CALIBRATE_ON: prdata = jsac_pkg::DATA_W'(cfg_r.calibrate_on);
      jsac_pkg::REG_WAKE_BELOW:   prdata = jsac_pkg::DATA_W'(cfg_r.wake_below);
      jsac_pkg::REG_WAKE_ABOVE:   prdata = jsac_pkg::DATA_W'(cfg_r.wake_above);
      jsac_pkg::REG_REST_LOW:     prdata = jsac_pkg::DATA_W'(cfg_r.rest_window_low);
      jsac_pkg::REG_REST_HIGH:    prdata = jsac_pkg::DATA_W'(cfg_r.rest_window_high);
      jsac_pkg::REG_DWELL_LIMIT:  prdata = jsac_pkg::DATA_W'(cfg_r.dwell_limit_ms);
      default:                    prdata = '0;
    endcase
  end

  // Input transfer and calibration update in the same cycle.
  assign in_ch.ready = (state_r == jsac_pkg::ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  jsac_cal u_cal (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .upd     (in_acc && cfg_r.calibrate_on),
    .sample  (in_ch.axis_value),
    .elapsed (in_ch.elapsed_ms),
    .cal     (cal)
  );

  always_ff @(posedge clk) begin
    if (in_acc) begin
      sample_r <= in_ch.axis_value;
    end
  end

  // Clamp to the updated range and pick the side of the dead band.
  always_comb begin
    if (sample_r < cal.range_low) begin
      x_clamp = cal.range_low;
    end else if (sample_r > cal.range_high) begin
      x_clamp = cal.range_high;
    end else begin
      x_clamp = sample_r;
    end
    pos_side = (x_clamp > cal.center_high) && (cal.center_high < cal.range_high);
    neg_side = !pos_side && (x_clamp < cal.center_low) && (cal.center_low > cal.range_low);
    div_req.start = (state_r == jsac_pkg::ST_SETUP) && (pos_side || neg_side);
    div_req.num   = pos_side ? (x_clamp - cal.center_high) : (cal.center_low - x_clamp);
    div_req.den   = pos_side ? (cal.range_high - cal.center_high)
                             : (cal.center_low - cal.range_low);
  end

  jsac_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .res   (div_res)
  );

  assign out_free = !out_valid_r || out_ch.ready;

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      jsac_pkg::ST_IDLE:  if (in_acc) state_nxt = jsac_pkg::ST_SETUP;
      jsac_pkg::ST_SETUP: state_nxt = div_req.start ? jsac_pkg::ST_DIV : jsac_pkg::ST_HOLD;
      jsac_pkg::ST_DIV:   if (div_res.done) state_nxt = jsac_pkg::ST_HOLD;
      jsac_pkg::ST_HOLD:  if (out_free) state_nxt = jsac_pkg::ST_IDLE;
      default:            state_nxt = jsac_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= jsac_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Signed deflection: zero in the dead band, negated on the low side.
  always_ff @(posedge clk) begin
    if (state_r == jsac_pkg::ST_SETUP) begin
      neg_r  <= neg_side;
      defl_r <= '0;
    end else if ((state_r == jsac_pkg::ST_DIV) && div_res.done) begin
      defl_r <= neg_r ? (~div_res.mag + 1'b1) : div_res.mag;
    end
  end

  // Output register: filled from the hold state, cleared when the sink takes it.
  assign mid_sum = {1'b0, cal.center_low} + {1'b0, cal.center_high};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == jsac_pkg::ST_HOLD) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == jsac_pkg::ST_HOLD) && out_free) begin
      out_defl_r  <= defl_r;
      out_rl_r    <= cal.range_low;
      out_rh_r    <= cal.range_high;
      out_cl_r    <= cal.center_low;
      out_ch_r    <= cal.center_high;
      out_mid_r   <= mid_sum[jsac_pkg::AXIS_W:1];
      out_armed_r <= cal.armed;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.deflection      = out_defl_r;
  assign out_ch.out_range_low   = out_rl_r;
  assign out_ch.out_range_high  = out_rh_r;
  assign out_ch.out_center_low  = out_cl_r;
  assign out_ch.out_center_high = out_ch_r;
  assign out_ch.out_center_mid  = out_mid_r;
  assign out_ch.out_armed       = out_armed_r;

endmodule

// ===== hdl/jsac_cal.sv =====
// Calibration state: arming, range tracking and dead band learning.
module jsac_cal (
  input  logic                        clk,
  input  logic                        rst_n,
  input  jsac_pkg::cfg_t              cfg,
  input  logic                        upd,
  input  logic [jsac_pkg::AXIS_W-1:0] sample,
  input  logic [jsac_pkg::TIME_W-1:0] elapsed,
  output jsac_pkg::cal_t              cal
);

  logic                        armed_r, armed_nxt;
  logic [jsac_pkg::TIME_W-1:0] dwell_r, dwell_nxt;
  logic [jsac_pkg::AXIS_W-1:0] rl_r, rl_nxt, rh_r, rh_nxt;
  logic [jsac_pkg::AXIS_W-1:0] cl_r, cl_nxt, ch_r, ch_nxt;

  logic                        wake, in_rest, restart;
  logic [jsac_pkg::TIME_W-1:0] dwell_base, dwell_sat;
  logic [jsac_pkg::TIME_W:0]   dwell_sum;
  logic [jsac_pkg::AXIS_W-1:0] rl_base, rh_base, cl_base, ch_base;

  // Next calibration state for the sample on the input channel.
  always_comb begin
    wake       = (sample < cfg.wake_below) || (sample > cfg.wake_above);
    armed_nxt  = armed_r | wake;
    dwell_base = armed_r ? dwell_r : '0;
    rl_base    = (!armed_r && wake) ? sample : rl_r;
    rh_base    = (!armed_r && wake) ? sample : rh_r;
    in_rest    = (sample >= cfg.rest_window_low) && (sample <= cfg.rest_window_high);
    restart    = dwell_base < cfg.dwell_limit_ms;
    dwell_sum  = {1'b0, dwell_base} + {1'b0, elapsed};
    dwell_sat  = (dwell_sum > {1'b0, cfg.dwell_limit_ms}) ? cfg.dwell_limit_ms
                                                          : dwell_sum[jsac_pkg::TIME_W-1:0];
    cl_base    = restart ? sample : cl_r;
    ch_base    = restart ? sample : ch_r;

    rl_nxt    = rl_base;
    rh_nxt    = rh_base;
    cl_nxt    = cl_r;
    ch_nxt    = ch_r;
    dwell_nxt = '0;
    if (armed_nxt) begin
      rl_nxt = (sample < rl_base) ? sample : rl_base;
      rh_nxt = (sample > rh_base) ? sample : rh_base;
      if (in_rest) begin
        dwell_nxt = dwell_sat;
        cl_nxt    = cl_base;
        ch_nxt    = ch_base;
        // Once the dwell limit is reached the band only grows.
        if (dwell_sat >= cfg.dwell_limit_ms) begin
          cl_nxt = (sample < cl_base) ? sample : cl_base;
          ch_nxt = (sample > ch_base) ? sample : ch_base;
        end
      end
    end
  end

  // State registers, written once per accepted sample while calibration is on.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r <= 1'b0;
      dwell_r <= '0;
      rl_r    <= jsac_pkg::RST_RANGE_LOW;
      rh_r    <= jsac_pkg::RST_RANGE_HIGH;
      cl_r    <= jsac_pkg::RST_CENTER_LOW;
      ch_r    <= jsac_pkg::RST_CENTER_HIGH;
    end else if (upd) begin
      armed_r <= armed_nxt;
      dwell_r <= dwell_nxt;
      rl_r    <= rl_nxt;
      rh_r    <= rh_nxt;
      cl_r    <= cl_nxt;
      ch_r    <= ch_nxt;
    end
  end

  assign cal = '{armed: armed_r, range_low: rl_r, range_high: rh_r,
                 center_low: cl_r, center_high: ch_r};

endmodule

// ===== hdl/jsac_div.sv =====
// Bit-serial restoring divider giving num * 32768 / den, saturated to 32767.
module jsac_div (
  input  logic               clk,
  input  logic               rst_n,
  input  jsac_pkg::div_req_t req,
  output jsac_pkg::div_res_t res
);

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic                        full_r, full_nxt;
  logic [jsac_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [jsac_pkg::AXIS_W-1:0] rem_r, rem_nxt;
  logic [jsac_pkg::AXIS_W-1:0] den_r, den_nxt;
  logic [jsac_pkg::DEFL_W-1:0] quo_r, quo_nxt;
  logic [jsac_pkg::AXIS_W:0]   trial;
  logic                        take;

  // One quotient bit per cycle; the remainder stays below the divisor whenever the numerator is below it.
  always_comb begin
    trial    = {rem_r, 1'b0};
    take     = trial >= {1'b0, den_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    full_nxt = full_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      full_nxt = (req.num == req.den);
      cnt_nxt  = jsac_pkg::CNT_W'(jsac_pkg::DIV_STEPS);
      rem_nxt  = req.num;
      den_nxt  = req.den;
      quo_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = take ? jsac_pkg::AXIS_W'(trial - {1'b0, den_r})
                     : trial[jsac_pkg::AXIS_W-1:0];
      quo_nxt = {quo_r[jsac_pkg::DEFL_W-2:0], take};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == jsac_pkg::CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath registers carry no reset.
  always_ff @(posedge clk) begin
    full_r <= full_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    quo_r  <= quo_nxt;
  end

  // A numerator equal to the divisor is full scale, which saturates.
  assign res = '{done: done_r, mag: full_r ? jsac_pkg::MAX_MAG : quo_r};

endmodule

// ===== hdl/jsac_checker.sv =====
// Port-level checker for the auto-calibration unit, with its bind statement.
module jsac_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [jsac_pkg::DEFL_W-1:0]  deflection,
  input logic [jsac_pkg::AXIS_W-1:0]  range_low,
  input logic [jsac_pkg::AXIS_W-1:0]  range_high,
  input logic [jsac_pkg::AXIS_W-1:0]  center_low,
  input logic [jsac_pkg::AXIS_W-1:0]  center_high
);

  // A result held back by the sink stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before transfer");

  // One sample at a time: the input closes right after a transfer.
  a_in_closes: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input still open after a transfer");

  // Saturation keeps the deflection symmetric.
  a_defl_sym: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> deflection != 16'h8000)
    else $error("deflection reached negative full scale");

  // Calibrated range and dead band are always ordered.
  a_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (range_low <= range_high) && (center_low <= center_high))
    else $error("calibration bounds out of order");

endmodule

bind joystick_axis_autocal_normalizer_unit jsac_checker u_jsac_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .deflection  (out_ch.deflection),
  .range_low   (out_ch.out_range_low),
  .range_high  (out_ch.out_range_high),
  .center_low  (out_ch.out_center_low),
  .center_high (out_ch.out_center_high)
);

// ===== sim/tb_joystick_axis_autocal_normalizer_unit.sv =====
// Self-checking testbench for the single-axis joystick auto-calibration and normalisation unit.
`timescale 1ns / 100ps

module tb_joystick_axis_autocal_normalizer_unit;

  localparam int unsigned FULL_SCALE  = 32768;
  localparam int          LONG_HOLD   = 300;
  localparam int          STALL_LIMIT = 2000;
  localparam int          SHOWN_ERRS  = 10;

  // Indexes past the six registers; writes there must be ignored.
  localparam logic [jsac_pkg::IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [jsac_pkg::IDX_W-1:0] REG_SPARE_7 = 3'd7;

  // One normalised result as the sink sees it.
  typedef struct packed {
    logic signed [jsac_pkg::DEFL_W-1:0] deflection;
    logic [jsac_pkg::AXIS_W-1:0]        range_low;
    logic [jsac_pkg::AXIS_W-1:0]        range_high;
    logic [jsac_pkg::AXIS_W-1:0]        center_low;
    logic [jsac_pkg::AXIS_W-1:0]        center_high;
    logic [jsac_pkg::AXIS_W-1:0]        center_mid;
    logic                               armed;
  } axis_result_t;

  logic                        clk;
  logic                        rst_n;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [jsac_pkg::ADDR_W-1:0] paddr;
  logic [jsac_pkg::DATA_W-1:0] pwdata;
  logic [jsac_pkg::DATA_W-1:0] prdata;
  logic                        pready;

  jsac_in_if  in_ch ();
  jsac_out_if out_ch ();

  joystick_axis_autocal_normalizer_unit i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Expected results in transfer order, and the run's error count.
  axis_result_t pending_results[$];
  int           mismatches;
  int           idle_pct;
  // Long hold-offs asked for by the stimulus, and those the sink has served.
  int           hold_asked;
  int           hold_given;

  // Our own copy of the configuration and the calibration state.
  jsac_pkg::cfg_t              cal_cfg;
  logic                        cal_armed;
  logic [jsac_pkg::TIME_W-1:0] cal_dwell;
  logic [jsac_pkg::AXIS_W-1:0] cal_range_lo;
  logic [jsac_pkg::AXIS_W-1:0] cal_range_hi;
  logic [jsac_pkg::AXIS_W-1:0] cal_band_lo;
  logic [jsac_pkg::AXIS_W-1:0] cal_band_hi;

  // Clock with a 4 ns period.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Deflection of a sample against the current calibration.
  function automatic logic signed [jsac_pkg::DEFL_W-1:0] deflection_of(
      input logic [jsac_pkg::AXIS_W-1:0] v);
    int unsigned x;
    int unsigned mag;
    x = 32'(v);
    if (x < cal_range_lo) x = 32'(cal_range_lo);
    else if (x > cal_range_hi) x = 32'(cal_range_hi);
    if (x > cal_band_hi && cal_band_hi < cal_range_hi) begin
      mag = ((x - cal_band_hi) * FULL_SCALE) / (int'(cal_range_hi) - int'(cal_band_hi));
      if (mag > jsac_pkg::MAX_MAG) mag = 32'(jsac_pkg::MAX_MAG);
      return jsac_pkg::DEFL_W'(mag);
    end
    if (x < cal_band_lo && cal_band_lo > cal_range_lo) begin
      mag = ((cal_band_lo - x) * FULL_SCALE) / (int'(cal_band_lo) - int'(cal_range_lo));
      if (mag > jsac_pkg::MAX_MAG) mag = 32'(jsac_pkg::MAX_MAG);
      return -jsac_pkg::DEFL_W'(mag);
    end
    return '0;
  endfunction

  // Apply one sample to the calibration and queue the result it should give.
  task automatic predict_sample(input logic [jsac_pkg::AXIS_W-1:0] v,
                                input logic [jsac_pkg::TIME_W-1:0] dt);
    int unsigned  t;
    logic [8:0]   mid_sum;
    axis_result_t r;
    if (cal_cfg.calibrate_on) begin
      if (!cal_armed) begin
        cal_dwell = '0;
        if (v < cal_cfg.wake_below || v > cal_cfg.wake_above) begin
          cal_armed    = 1'b1;
          cal_range_lo = v;
          cal_range_hi = v;
        end
      end
      if (cal_armed) begin
        if (v < cal_range_lo) cal_range_lo = v;
        if (v > cal_range_hi) cal_range_hi = v;
        if (v >= cal_cfg.rest_window_low && v <= cal_cfg.rest_window_high) begin
          // Before the dwell limit the band restarts; after it the band widens.
          if (cal_dwell < cal_cfg.dwell_limit_ms) begin
            cal_band_lo = v;
            cal_band_hi = v;
          end
          t = int'(cal_dwell) + int'(dt);
          if (t > cal_cfg.dwell_limit_ms) t = 32'(cal_cfg.dwell_limit_ms);
          cal_dwell = jsac_pkg::TIME_W'(t);
          if (cal_dwell >= cal_cfg.dwell_limit_ms) begin
            if (v < cal_band_lo) cal_band_lo = v;
            if (v > cal_band_hi) cal_band_hi = v;
          end
        end else begin
          cal_dwell = '0;
        end
      end
    end
    mid_sum       = {1'b0, cal_band_lo} + {1'b0, cal_band_hi};
    r.deflection  = deflection_of(v);
    r.range_low   = cal_range_lo;
    r.range_high  = cal_range_hi;
    r.center_low  = cal_band_lo;
    r.center_high = cal_band_hi;
    r.center_mid  = mid_sum[8:1];
    r.armed       = cal_armed;
    pending_results.push_back(r);
  endtask

  // Compare one value and report the first few differences.
  task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= SHOWN_ERRS)
        $display("mismatch on %s: expected %0h, got %0h", what, want, got);
    end
  endtask

  // Record the expectation for every sample transfer.
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
        predict_sample(in_ch.axis_value, in_ch.elapsed_ms);
    end
  end

  // Check every result transfer against the oldest expectation.
  initial begin
    axis_result_t want;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= SHOWN_ERRS)
            $display("result with no sample waiting: deflection %0h", out_ch.deflection);
        end else begin
          want = pending_results.pop_front();
          check_field("deflection", {16'h0, want.deflection}, {16'h0, out_ch.deflection});
          check_field("range_low", 32'(want.range_low), 32'(out_ch.out_range_low));
          check_field("range_high", 32'(want.range_high), 32'(out_ch.out_range_high));
          check_field("center_low", 32'(want.center_low), 32'(out_ch.out_center_low));
          check_field("center_high", 32'(want.center_high), 32'(out_ch.out_center_high));
          check_field("center_mid", 32'(want.center_mid), 32'(out_ch.out_center_mid));
          check_field("armed", 32'(want.armed), 32'(out_ch.out_armed));
        end
      end
    end
  end

  // Result sink: random stall bursts, plus one long hold-off on request.
  initial begin
    hold_given   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_given < hold_asked) begin
        hold_given++;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 11) - 1) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any transfer.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("tb_joystick_axis_autocal_normalizer_unit NOT OK");
    $finish;
  end

  // Offer one sample, with an occasional idle burst ahead of it, until it is taken.
  task automatic send_sample(input logic [jsac_pkg::AXIS_W-1:0] v,
                             input logic [jsac_pkg::TIME_W-1:0] dt);
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      in_ch.valid      <= 1'b0;
      in_ch.axis_value <= jsac_pkg::AXIS_W'($urandom);
      in_ch.elapsed_ms <= jsac_pkg::TIME_W'($urandom);
      repeat ($urandom_range(1, 11) - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid      <= 1'b1;
    in_ch.axis_value <= v;
    in_ch.elapsed_ms <= dt;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
  endtask

  // Stop offering samples and let every outstanding result arrive.
  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  // One APB setup and access phase.
  task automatic apb_transfer(input logic wr, input logic [jsac_pkg::IDX_W-1:0] idx,
                              input logic [jsac_pkg::DATA_W-1:0] wdata,
                              output logic [jsac_pkg::DATA_W-1:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write a register, mirror it, and read it back where it exists.
  task automatic write_reg(input logic [jsac_pkg::IDX_W-1:0] idx,
                           input logic [jsac_pkg::DATA_W-1:0] value);
    logic [jsac_pkg::DATA_W-1:0] rd;
    logic [jsac_pkg::DATA_W-1:0] want;
    bit                          known;
    known = 1'b1;
    want  = '0;
    apb_transfer(1'b1, idx, value, rd);
    case (idx)
      jsac_pkg::REG_CALIBRATE_ON: begin
        cal_cfg.calibrate_on = value[0];
        want = 32'(value[0]);
      end
      jsac_pkg::REG_WAKE_BELOW: begin
        cal_cfg.wake_below = value[jsac_pkg::AXIS_W-1:0];
        want = 32'(value[jsac_pkg::AXIS_W-1:0]);
      end
      jsac_pkg::REG_WAKE_ABOVE: begin
        cal_cfg.wake_above = value[jsac_pkg::AXIS_W-1:0];
        want = 32'(value[jsac_pkg::AXIS_W-1:0]);
      end
      jsac_pkg::REG_REST_LOW: begin
        cal_cfg.rest_window_low = value[jsac_pkg::AXIS_W-1:0];
        want = 32'(value[jsac_pkg::AXIS_W-1:0]);
      end
      jsac_pkg::REG_REST_HIGH: begin
        cal_cfg.rest_window_high = value[jsac_pkg::AXIS_W-1:0];
        want = 32'(value[jsac_pkg::AXIS_W-1:0]);
      end
      jsac_pkg::REG_DWELL_LIMIT: begin
        cal_cfg.dwell_limit_ms = value[jsac_pkg::TIME_W-1:0];
        want = 32'(value[jsac_pkg::TIME_W-1:0]);
      end
      default: known = 1'b0;
    endcase
    if (known) begin
      apb_transfer(1'b0, idx, '0, rd);
      check_field("register readback", want, rd);
    end
  endtask

  // Drain the block, then load the whole register set.
  task automatic set_config(input logic on, input logic [jsac_pkg::AXIS_W-1:0] wb,
                            input logic [jsac_pkg::AXIS_W-1:0] wa,
                            input logic [jsac_pkg::AXIS_W-1:0] rl,
                            input logic [jsac_pkg::AXIS_W-1:0] rh,
                            input logic [jsac_pkg::TIME_W-1:0] dl);
    wait_idle();
    write_reg(jsac_pkg::REG_CALIBRATE_ON, 32'(on));
    write_reg(jsac_pkg::REG_WAKE_BELOW, 32'(wb));
    write_reg(jsac_pkg::REG_WAKE_ABOVE, 32'(wa));
    write_reg(jsac_pkg::REG_REST_LOW, 32'(rl));
    write_reg(jsac_pkg::REG_REST_HIGH, 32'(rh));
    write_reg(jsac_pkg::REG_DWELL_LIMIT, 32'(dl));
  endtask

  // A sample inside the rest window, or anywhere if the window is inverted.
  function automatic logic [jsac_pkg::AXIS_W-1:0] rest_sample();
    if (cal_cfg.rest_window_low <= cal_cfg.rest_window_high)
      return jsac_pkg::AXIS_W'($urandom_range(cal_cfg.rest_window_high,
                                              cal_cfg.rest_window_low));
    return jsac_pkg::AXIS_W'($urandom_range(0, 255));
  endfunction

  // A sample that pushes on the range ends or the dead band edges.
  function automatic logic [jsac_pkg::AXIS_W-1:0] swing_sample();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return cal_range_lo - jsac_pkg::AXIS_W'($urandom_range(0, 3));
      3:       return cal_range_hi + jsac_pkg::AXIS_W'($urandom_range(0, 3));
      4:       return cal_band_lo - jsac_pkg::AXIS_W'($urandom_range(0, 4));
      default: return cal_band_hi + jsac_pkg::AXIS_W'($urandom_range(0, 4));
    endcase
  endfunction

  // Elapsed time, mostly short so that dwell builds up over several samples.
  function automatic logic [jsac_pkg::TIME_W-1:0] pick_elapsed();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return jsac_pkg::TIME_W'($urandom_range(0, 65535));
      3:       return cal_cfg.dwell_limit_ms;
      4:       return jsac_pkg::TIME_W'($urandom_range(0, 1023));
      default: return jsac_pkg::TIME_W'($urandom_range(1, 150));
    endcase
  endfunction

  // Gestures: rest runs, swings to the ends, and plain noise.
  task automatic run_random_traffic(input int count);
    int                          sent;
    int                          kind;
    int                          len;
    logic [jsac_pkg::AXIS_W-1:0] v;
    sent = 0;
    while (sent < count) begin
      kind = $urandom_range(0, 9);
      len  = $urandom_range(1, 16);
      for (int i = 0; i < len && sent < count; i++) begin
        if (kind < 5) v = rest_sample();
        else if (kind < 8) v = swing_sample();
        else v = jsac_pkg::AXIS_W'($urandom_range(0, 255));
        send_sample(v, pick_elapsed());
        sent++;
      end
    end
  endtask

  // Before arming: default calibration, then conversion with calibration off.
  task automatic test_unarmed_conversion();
    send_sample(8'd128, 16'd10);
    send_sample(8'd64, 16'd10);
    send_sample(8'd192, 16'd10);
    send_sample(8'd100, 16'd0);
    wait_idle();
    write_reg(jsac_pkg::REG_CALIBRATE_ON, 32'd0);
    send_sample(8'd0, 16'd100);
    send_sample(8'd255, 16'd65535);
  endtask

  // A wake window spanning everything never arms.
  task automatic test_wake_window_extremes();
    wait_idle();
    write_reg(jsac_pkg::REG_CALIBRATE_ON, 32'd1);
    write_reg(jsac_pkg::REG_WAKE_BELOW, 32'd0);
    write_reg(jsac_pkg::REG_WAKE_ABOVE, 32'd255);
    send_sample(8'd0, 16'd0);
    send_sample(8'd255, 16'd65535);
  endtask

  // Arming on a low sample, then full-scale deflection both ways.
  task automatic test_arming_full_scale();
    wait_idle();
    write_reg(jsac_pkg::REG_WAKE_BELOW, 32'(jsac_pkg::RST_WAKE_BELOW));
    write_reg(jsac_pkg::REG_WAKE_ABOVE, 32'(jsac_pkg::RST_WAKE_ABOVE));
    send_sample(8'd10, 16'd5);
    send_sample(8'd250, 16'd5);
    send_sample(8'd255, 16'd5);
  endtask

  // Dwell saturation: the band restarts, then widens, then dwell clears.
  task automatic test_dwell_center_band();
    send_sample(8'd128, 16'd200);
    send_sample(8'd130, 16'd200);
    send_sample(8'd126, 16'd200);
    send_sample(8'd140, 16'd65535);
    send_sample(8'd110, 16'd0);
    send_sample(8'd200, 16'd0);
  endtask

  // Dead band edges meeting the range ends give zero on that side.
  task automatic test_zero_width_sides();
    wait_idle();
    write_reg(jsac_pkg::REG_REST_LOW, 32'd0);
    write_reg(jsac_pkg::REG_REST_HIGH, 32'd255);
    write_reg(jsac_pkg::REG_DWELL_LIMIT, 32'd0);
    send_sample(8'd0, 16'd0);
    send_sample(8'd0, 16'd7);
    send_sample(8'd255, 16'd0);
    wait_idle();
    write_reg(jsac_pkg::REG_REST_LOW, 32'(jsac_pkg::RST_REST_LOW));
    write_reg(jsac_pkg::REG_REST_HIGH, 32'(jsac_pkg::RST_REST_HIGH));
    write_reg(jsac_pkg::REG_DWELL_LIMIT, 32'hFFFF);
    send_sample(8'd128, 16'd1);
  endtask

  // Windows given in the wrong order, and writes past the last register.
  task automatic test_inverted_windows_and_spare_regs();
    wait_idle();
    write_reg(jsac_pkg::REG_REST_LOW, 32'd200);
    write_reg(jsac_pkg::REG_REST_HIGH, 32'd50);
    write_reg(jsac_pkg::REG_WAKE_BELOW, 32'd200);
    write_reg(jsac_pkg::REG_WAKE_ABOVE, 32'd50);
    write_reg(REG_SPARE_6, $urandom);
    write_reg(REG_SPARE_7, $urandom);
    send_sample(8'd128, 16'd100);
    send_sample(8'd30, 16'd1000);
  endtask

  // Random traffic under a series of settings, the extremes among them.
  task automatic test_random_settings();
    logic [jsac_pkg::AXIS_W-1:0] lo;
    idle_pct = 25;
    set_config(jsac_pkg::RST_CALIBRATE_ON, jsac_pkg::RST_WAKE_BELOW, jsac_pkg::RST_WAKE_ABOVE,
               jsac_pkg::RST_REST_LOW, jsac_pkg::RST_REST_HIGH, jsac_pkg::RST_DWELL_LIMIT);
    run_random_traffic(200);
    idle_pct = 10;
    set_config(1'b1, 8'd64, 8'd192, 8'd0, 8'd255, 16'd0);
    run_random_traffic(200);
    idle_pct = 40;
    lo = jsac_pkg::AXIS_W'($urandom_range(80, 140));
    set_config(1'b1, 8'd255, 8'd0, lo, lo + jsac_pkg::AXIS_W'($urandom_range(0, 30)),
               16'hFFFF);
    run_random_traffic(200);
    idle_pct = 15;
    set_config(1'b0, 8'd0, 8'd255, 8'd90, 8'd170, 16'd300);
    run_random_traffic(100);
    for (int p = 0; p < 2; p++) begin
      idle_pct = $urandom_range(0, 30);
      set_config(1'b1, jsac_pkg::AXIS_W'($urandom), jsac_pkg::AXIS_W'($urandom),
                 jsac_pkg::AXIS_W'($urandom), jsac_pkg::AXIS_W'($urandom),
                 jsac_pkg::TIME_W'($urandom_range(0, 2000)));
      run_random_traffic(200);
    end
  endtask

  // The sink holds off for a long stretch while samples keep coming.
  task automatic test_output_backpressure();
    idle_pct = 0;
    set_config(1'b1, jsac_pkg::RST_WAKE_BELOW, jsac_pkg::RST_WAKE_ABOVE,
               jsac_pkg::RST_REST_LOW, jsac_pkg::RST_REST_HIGH, 16'd250);
    hold_asked++;
    run_random_traffic(40);
  endtask

  // Back-to-back transfers with no idling on either side.
  task automatic test_steady_stream();
    idle_pct = 0;
    run_random_traffic(200);
  endtask

  // Stimulus sequence and final verdict.
  initial begin
    rst_n            = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    in_ch.valid      = 1'b0;
    in_ch.axis_value = '0;
    in_ch.elapsed_ms = '0;
    mismatches       = 0;
    idle_pct         = 20;
    hold_asked       = 0;

    // Mirror of the reset state.
    cal_cfg.calibrate_on     = jsac_pkg::RST_CALIBRATE_ON;
    cal_cfg.wake_below       = jsac_pkg::RST_WAKE_BELOW;
    cal_cfg.wake_above       = jsac_pkg::RST_WAKE_ABOVE;
    cal_cfg.rest_window_low  = jsac_pkg::RST_REST_LOW;
    cal_cfg.rest_window_high = jsac_pkg::RST_REST_HIGH;
    cal_cfg.dwell_limit_ms   = jsac_pkg::RST_DWELL_LIMIT;
    cal_armed    = 1'b0;
    cal_dwell    = '0;
    cal_range_lo = jsac_pkg::RST_RANGE_LOW;
    cal_range_hi = jsac_pkg::RST_RANGE_HIGH;
    cal_band_lo  = jsac_pkg::RST_CENTER_LOW;
    cal_band_hi  = jsac_pkg::RST_CENTER_HIGH;

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    test_unarmed_conversion();
    test_wake_window_extremes();
    test_arming_full_scale();
    test_dwell_center_band();
    test_zero_width_sides();
    test_inverted_windows_and_spare_regs();
    test_random_settings();
    test_output_backpressure();
    test_steady_stream();

    wait_idle();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("tb_joystick_axis_autocal_normalizer_unit OK");
    else
      $display("tb_joystick_axis_autocal_normalizer_unit NOT OK");
    $finish;
  end

endmodule
